// ===== hw/rtl/icsp_pkg.sv =====
// ----------------------------------------------------------------------------
// icsp_pkg
// Shared types and constants of the image container stream parser.
// ----------------------------------------------------------------------------
package icsp_pkg;

    localparam int COUNT_W          = 64;
    localparam int HALF_W           = COUNT_W / 2;
    localparam int MAGIC_LEN        = 4;
    localparam int FIXED_HDR_BYTES  = 36;

    localparam logic [7:0] CHAR_C   = 8'h43;
    localparam logic [7:0] CHAR_I   = 8'h49;
    localparam logic [7:0] CHAR_F   = 8'h46;
    localparam logic [7:0] CHAR_NL  = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    // Controller states: parse phases plus the size check sequence
    typedef enum logic [3:0] {
        ST_MAGIC,
        ST_HEADER,
        ST_CAPTION,
        ST_TAGS,
        ST_PIXELS,
        ST_DONE,
        ST_ERROR,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_CHECK
    } state_t;

    typedef enum logic [3:0] {
        ROLE_MAGIC    = 4'd0,
        ROLE_HEADER   = 4'd1,
        ROLE_CAP_CHAR = 4'd2,
        ROLE_CAP_END  = 4'd3,
        ROLE_TAG_CHAR = 4'd4,
        ROLE_TAG_END  = 4'd5,
        ROLE_RED      = 4'd6,
        ROLE_GREEN    = 4'd7,
        ROLE_BLUE     = 4'd8,
        ROLE_IGNORED  = 4'd9,
        ROLE_END      = 4'd10
    } role_t;

    typedef enum logic [3:0] {
        ERR_NONE        = 4'd0,
        ERR_BAD_MAGIC   = 4'd1,
        ERR_SIZE        = 4'd2,
        ERR_EOF_CAPTION = 4'd3,
        ERR_LONG_HEADER = 4'd4,
        ERR_EOF_TAGS    = 4'd5,
        ERR_TAG_UNTERM  = 4'd6,
        ERR_EOF_PIXELS  = 4'd7,
        ERR_EOF_HEADER  = 4'd8
    } err_t;

    // Multiplier sequence operations
    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_START,
        MOP_CROSS1,
        MOP_CROSS2,
        MOP_FINISH
    } mul_op_t;

    typedef enum logic [1:0] {
        VAL_INPUT,
        VAL_HELD,
        VAL_ZERO
    } val_sel_t;

    typedef struct packed {
        logic     clear;
        logic     hbs_inc;
        logic     hdr_shift;
        logic     pix_inc;
        mul_op_t  mul_op;
        logic     out_load;
        val_sel_t val_sel;
        role_t    role;
        err_t     err;
        logic     done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       magic_match;
        logic       magic_last;
        logic       hdr_last;
        logic       count_reached;
        logic       byte_nl;
        logic       byte_zero;
        logic       content_zero;
        logic       pix_last;
        logic       size_ok;
        logic       out_free;
        logic [1:0] pix_color;
    } dp_status_t;

    function automatic logic [7:0] magic_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = CHAR_C;
            2'd1:    c = CHAR_I;
            default: c = CHAR_F;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/icsp_ifs.sv =====
// ----------------------------------------------------------------------------
// icsp_ifs
// Valid/ready channels: file bytes in, classified bytes out.
// ----------------------------------------------------------------------------
interface icsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface icsp_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] byte_role;
    logic [7:0] byte_value;
    logic [3:0] error_code;
    logic       image_done;

    modport source (output valid, output byte_role, output byte_value,
                    output error_code, output image_done, input ready);
    modport sink   (input valid, input byte_role, input byte_value,
                    input error_code, input image_done, output ready);
endinterface

// ===== hw/rtl/icsp_datapath.sv =====
// ----------------------------------------------------------------------------
// icsp_datapath
// Counters, header fields, shared 32x32 multiplier and the output register.
// ----------------------------------------------------------------------------
module icsp_datapath
    import icsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    input  logic        out_ready,
    output logic        out_valid,
    output role_t       out_role,
    output logic [7:0]  out_value,
    output err_t        out_err,
    output logic        out_done
);

    logic [COUNT_W-1:0] hbs_reg, hbs_next;
    logic [COUNT_W-1:0] pix_reg, pix_next;
    logic [1:0]         color_reg, color_next;
    logic               out_valid_reg, out_valid_next;

    logic [COUNT_W-1:0] hsize_reg, csize_reg, width_reg, height_reg;
    logic [COUNT_W-1:0] prod_reg, acc_reg;
    logic [7:0]         held_reg;
    role_t              role_reg;
    logic [7:0]         value_reg;
    err_t               err_reg;
    logic               done_reg;

    logic [COUNT_W-1:0] hbs_plus;
    logic [COUNT_W-1:0] pix_plus;
    logic [COUNT_W-1:0] triple;
    logic [5:0]         hdr_off;
    logic [HALF_W-1:0]  mul_a, mul_b;
    logic [COUNT_W-1:0] mul_p;
    logic [COUNT_W-1:0] cross_term;
    logic               out_free;

    assign hbs_plus   = hbs_reg + 64'd1;
    assign pix_plus   = pix_reg + 64'd1;
    assign hdr_off    = hbs_reg[5:0] - 6'(MAGIC_LEN);
    assign cross_term = {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
    assign triple     = acc_reg + {acc_reg[COUNT_W-2:0], 1'b0};
    assign out_free   = !out_valid_reg || out_ready;

    // Status toward the controller
    always_comb
    begin
        status.magic_match   = (data_byte == magic_char(hbs_reg[1:0]));
        status.magic_last    = (hbs_reg[1:0] == 2'(MAGIC_LEN - 1));
        status.hdr_last      = (hbs_reg[5:0] == 6'(FIXED_HDR_BYTES - 1));
        status.count_reached = (hbs_plus >= hsize_reg);
        status.byte_nl       = (data_byte == CHAR_NL);
        status.byte_zero     = (data_byte == CHAR_NUL);
        status.content_zero  = (csize_reg == '0);
        status.pix_last      = (pix_plus == csize_reg);
        status.size_ok       = (csize_reg == triple);
        status.out_free      = out_free;
        status.pix_color     = color_reg;
    end

    // Shared multiplier operand select: low64(w*h) from 32-bit halves
    always_comb
    begin
        case (cmd.mul_op)
            MOP_START:
            begin
                mul_a = width_reg[HALF_W-1:0];
                mul_b = height_reg[HALF_W-1:0];
            end
            MOP_CROSS1:
            begin
                mul_a = width_reg[HALF_W-1:0];
                mul_b = height_reg[COUNT_W-1:HALF_W];
            end
            default:
            begin
                mul_a = width_reg[COUNT_W-1:HALF_W];
                mul_b = height_reg[HALF_W-1:0];
            end
        endcase
        mul_p = COUNT_W'(mul_a) * COUNT_W'(mul_b);
    end

    // Counter next values
    always_comb
    begin
        hbs_next       = hbs_reg;
        pix_next       = pix_reg;
        color_next     = color_reg;
        out_valid_next = out_valid_reg;
        if (cmd.clear)
        begin
            hbs_next   = '0;
            pix_next   = '0;
            color_next = 2'd0;
        end
        else
        begin
            if (cmd.hbs_inc)
                hbs_next = hbs_plus;
            if (cmd.pix_inc)
            begin
                pix_next   = pix_plus;
                color_next = (color_reg == 2'd2) ? 2'd0 : color_reg + 2'd1;
            end
        end
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hbs_reg       <= '0;
            pix_reg       <= '0;
            color_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hbs_reg       <= hbs_next;
            pix_reg       <= pix_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        // header fields arrive little-endian: shift each byte in from the top
        if (cmd.hdr_shift)
        begin
            case (hdr_off[4:3])
                2'd0:    hsize_reg  <= {data_byte, hsize_reg[COUNT_W-1:8]};
                2'd1:    csize_reg  <= {data_byte, csize_reg[COUNT_W-1:8]};
                2'd2:    width_reg  <= {data_byte, width_reg[COUNT_W-1:8]};
                default: height_reg <= {data_byte, height_reg[COUNT_W-1:8]};
            endcase
            held_reg <= data_byte;
        end

        // multiply-accumulate sequence
        case (cmd.mul_op)
            MOP_START:
                prod_reg <= mul_p;
            MOP_CROSS1:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            MOP_CROSS2:
            begin
                acc_reg  <= acc_reg + cross_term;
                prod_reg <= mul_p;
            end
            MOP_FINISH:
                acc_reg  <= acc_reg + cross_term;
            default:
                ;
        endcase

        if (cmd.out_load)
        begin
            role_reg <= cmd.role;
            err_reg  <= cmd.err;
            done_reg <= cmd.done;
            case (cmd.val_sel)
                VAL_HELD:  value_reg <= held_reg;
                VAL_ZERO:  value_reg <= 8'd0;
                default:   value_reg <= data_byte;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_role  = role_reg;
    assign out_value = value_reg;
    assign out_err   = err_reg;
    assign out_done  = done_reg;

endmodule

// ===== hw/rtl/icsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// icsp_ctrl
// Parse state machine: classifies each byte and sequences the size check.
// ----------------------------------------------------------------------------
module icsp_ctrl
    import icsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       end_of_file,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    err_t   sticky_reg, sticky_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_MAGIC;
            sticky_reg <= ERR_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            sticky_reg <= sticky_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        sticky_next = sticky_reg;
        in_ready    = 1'b0;
        cmd         = '{clear: 1'b0, hbs_inc: 1'b0, hdr_shift: 1'b0, pix_inc: 1'b0,
                        mul_op: MOP_NONE, out_load: 1'b0, val_sel: VAL_INPUT,
                        role: ROLE_IGNORED, err: ERR_NONE, done: 1'b0};

        unique case (state_reg) inside
            ST_MUL0:
            begin
                cmd.mul_op = MOP_START;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul_op = MOP_CROSS1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_op = MOP_CROSS2;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.mul_op = MOP_FINISH;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // last header byte is reported once the product is known
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.val_sel  = VAL_HELD;
                    cmd.role     = ROLE_HEADER;
                    if (status.size_ok)
                        state_next = ST_CAPTION;
                    else
                    begin
                        cmd.err     = ERR_SIZE;
                        sticky_next = ERR_SIZE;
                        state_next  = ST_ERROR;
                    end
                end
            end
            ST_MAGIC, ST_HEADER, ST_CAPTION, ST_TAGS, ST_PIXELS, ST_DONE, ST_ERROR:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (end_of_file)
                    begin
                        // close the file and re-arm
                        cmd.clear   = 1'b1;
                        cmd.role    = ROLE_END;
                        cmd.val_sel = VAL_ZERO;
                        sticky_next = ERR_NONE;
                        state_next  = ST_MAGIC;
                        case (state_reg)
                            ST_MAGIC:   cmd.err = ERR_BAD_MAGIC;
                            ST_HEADER:  cmd.err = ERR_EOF_HEADER;
                            ST_CAPTION: cmd.err = ERR_EOF_CAPTION;
                            ST_TAGS:    cmd.err = ERR_EOF_TAGS;
                            ST_PIXELS:  cmd.err = ERR_EOF_PIXELS;
                            ST_ERROR:   cmd.err = sticky_reg;
                            default:    cmd.err = ERR_NONE;
                        endcase
                    end
                    else
                    begin
                        case (state_reg)
                            ST_MAGIC:
                            begin
                                cmd.role = ROLE_MAGIC;
                                if (!status.magic_match)
                                begin
                                    cmd.err     = ERR_BAD_MAGIC;
                                    sticky_next = ERR_BAD_MAGIC;
                                    state_next  = ST_ERROR;
                                end
                                else
                                begin
                                    cmd.hbs_inc = 1'b1;
                                    if (status.magic_last)
                                        state_next = ST_HEADER;
                                end
                            end
                            ST_HEADER:
                            begin
                                cmd.role      = ROLE_HEADER;
                                cmd.hbs_inc   = 1'b1;
                                cmd.hdr_shift = 1'b1;
                                // last byte waits for the size check
                                if (status.hdr_last)
                                begin
                                    cmd.out_load = 1'b0;
                                    state_next   = ST_MUL0;
                                end
                            end
                            ST_CAPTION:
                            begin
                                cmd.hbs_inc = 1'b1;
                                if (status.byte_nl)
                                begin
                                    cmd.role   = ROLE_CAP_END;
                                    state_next = ST_TAGS;
                                end
                                else
                                begin
                                    cmd.role = ROLE_CAP_CHAR;
                                    if (status.count_reached)
                                    begin
                                        cmd.err     = ERR_LONG_HEADER;
                                        sticky_next = ERR_LONG_HEADER;
                                        state_next  = ST_ERROR;
                                    end
                                end
                            end
                            ST_TAGS:
                            begin
                                cmd.hbs_inc = 1'b1;
                                cmd.role    = status.byte_zero ? ROLE_TAG_END : ROLE_TAG_CHAR;
                                if (status.count_reached)
                                begin
                                    if (!status.byte_zero)
                                    begin
                                        cmd.err     = ERR_TAG_UNTERM;
                                        sticky_next = ERR_TAG_UNTERM;
                                        state_next  = ST_ERROR;
                                    end
                                    else if (status.content_zero)
                                    begin
                                        cmd.done   = 1'b1;
                                        state_next = ST_DONE;
                                    end
                                    else
                                        state_next = ST_PIXELS;
                                end
                            end
                            ST_PIXELS:
                            begin
                                cmd.pix_inc = 1'b1;
                                case (status.pix_color)
                                    2'd0:    cmd.role = ROLE_RED;
                                    2'd1:    cmd.role = ROLE_GREEN;
                                    default: cmd.role = ROLE_BLUE;
                                endcase
                                if (status.pix_last)
                                begin
                                    cmd.done   = 1'b1;
                                    state_next = ST_DONE;
                                end
                            end
                            ST_ERROR:
                            begin
                                cmd.role = ROLE_IGNORED;
                                cmd.err  = sticky_reg;
                            end
                            default:
                                cmd.role = ROLE_IGNORED;
                        endcase
                    end
                end
            end
            default:
                state_next = ST_MAGIC;
        endcase
    end

endmodule

// ===== hw/rtl/image_container_stream_parser_top.sv =====
// Each byte's result is registered and shown in the cycle after its transfer.
// The last fixed header byte waits while the 64-bit size product is built in
// ST_MUL0 to ST_MUL3 with one shared 32x32 multiplier and then checked in ST_CHECK.
// Throughput: one byte per cycle while the output is taken and no size check runs.
// Reset (rst_n low, asynchronous) returns the parser to the magic phase with an
// empty output register.
// ----------------------------------------------------------------------------
// image_container_stream_parser_top
// Streaming container validator: tags each file byte with its role and errors.
// ----------------------------------------------------------------------------
module image_container_stream_parser_top
    import icsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    icsp_byte_if.sink     stream,
    icsp_result_if.source verdict
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       in_ready;
    role_t      out_role;
    err_t       out_err;

    icsp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (stream.valid),
        .end_of_file (stream.end_of_file),
        .in_ready    (in_ready),
        .status      (status),
        .cmd         (cmd)
    );

    icsp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (stream.data_byte),
        .cmd       (cmd),
        .status    (status),
        .out_ready (verdict.ready),
        .out_valid (verdict.valid),
        .out_role  (out_role),
        .out_value (verdict.byte_value),
        .out_err   (out_err),
        .out_done  (verdict.image_done)
    );

    assign stream.ready       = in_ready;
    assign verdict.byte_role  = out_role;
    assign verdict.error_code = out_err;

endmodule

// ===== hw/rtl/icsp_checker.sv =====
// ----------------------------------------------------------------------------
// icsp_checker
// Port-level checks on the parser output, bound to the top level.
// ----------------------------------------------------------------------------
module icsp_checker
    import icsp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] byte_role,
    input logic [7:0] byte_value,
    input logic [3:0] error_code,
    input logic       image_done
);

    // a pending result stays until it is taken
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    // end items carry no byte and never complete an image
    a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_role == ROLE_END |-> byte_value == 8'd0 && !image_done)
        else $error("end item with payload");

    // a completed image has no error
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_done |-> error_code == ERR_NONE)
        else $error("image done with error");

    // pixel bytes are only classified on an error-free stream
    a_pixel_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_role == ROLE_RED || byte_role == ROLE_GREEN ||
                      byte_role == ROLE_BLUE) |-> error_code == ERR_NONE)
        else $error("pixel byte with error");

    // output register is empty after any clock edge seen in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind image_container_stream_parser_top icsp_checker u_icsp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (verdict.valid),
    .out_ready  (verdict.ready),
    .byte_role  (verdict.byte_role),
    .byte_value (verdict.byte_value),
    .error_code (verdict.error_code),
    .image_done (verdict.image_done)
);

// ===== tb/icsp_parse_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icsp_parse_monitor
// Watches the byte and verdict channels of the container parser, predicts
// the role, echo, error and done flag of every byte transfer and compares
// each verdict transfer against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module icsp_parse_monitor
    import icsp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    icsp_byte_if   stream,
    icsp_result_if verdict,
    output int     fail_count,
    output int     pending_count
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        role_t      role;
        logic [7:0] value;
        err_t       err;
        logic       done;
    } byte_verdict_t;

    // Parser state as predicted
    state_t      phase;
    logic [63:0] hdr_count;
    logic [63:0] hdr_size;
    logic [63:0] body_size;
    logic [63:0] img_w;
    logic [63:0] img_h;
    logic [63:0] pix_count;
    logic        tag_zero_last;
    err_t        sticky_err;

    byte_verdict_t verdict_q[$];
    byte_verdict_t predicted;
    byte_verdict_t oldest;

    task automatic clear_parse_state();
        phase         = ST_MAGIC;
        hdr_count     = '0;
        hdr_size      = '0;
        body_size     = '0;
        img_w         = '0;
        img_h         = '0;
        pix_count     = '0;
        tag_zero_last = 1'b1;
        sticky_err    = ERR_NONE;
    endtask

    task automatic enter_error(input err_t code, output err_t shown);
        sticky_err = code;
        phase      = ST_ERROR;
        shown      = code;
    endtask

    // One step of the parser: classify a byte or close the file
    task automatic classify_byte(input logic [7:0] b, input logic eof,
                                 output byte_verdict_t v);
        logic [7:0]  want_char;
        logic [4:0]  idx;
        logic [63:0] part;
        v.role  = ROLE_IGNORED;
        v.value = b;
        v.err   = ERR_NONE;
        v.done  = 1'b0;
        if (eof) begin
            v.role  = ROLE_END;
            v.value = 8'h00;
            case (phase)
                ST_MAGIC:   v.err = ERR_BAD_MAGIC;
                ST_HEADER:  v.err = ERR_EOF_HEADER;
                ST_CAPTION: v.err = ERR_EOF_CAPTION;
                ST_TAGS:    v.err = ERR_EOF_TAGS;
                ST_PIXELS:  v.err = ERR_EOF_PIXELS;
                ST_ERROR:   v.err = sticky_err;
                default:    v.err = ERR_NONE;
            endcase
            clear_parse_state();
        end else begin
            case (phase)
                ST_MAGIC:
                begin
                    v.role = ROLE_MAGIC;
                    case (hdr_count[1:0])
                        2'd0:    want_char = CHAR_C;
                        2'd1:    want_char = CHAR_I;
                        default: want_char = CHAR_F;
                    endcase
                    if (b != want_char) begin
                        enter_error(ERR_BAD_MAGIC, v.err);
                    end else begin
                        hdr_count = hdr_count + 1;
                        if (hdr_count >= MAGIC_LEN)
                            phase = ST_HEADER;
                    end
                end
                ST_HEADER:
                begin
                    v.role = ROLE_HEADER;
                    idx    = 5'(hdr_count - 64'd4);
                    part   = {56'd0, b} << (idx[2:0] * 8);
                    case (idx[4:3])
                        2'd0:    hdr_size  = hdr_size | part;
                        2'd1:    body_size = body_size | part;
                        2'd2:    img_w     = img_w | part;
                        default: img_h     = img_h | part;
                    endcase
                    hdr_count = hdr_count + 1;
                    if (hdr_count >= FIXED_HDR_BYTES) begin
                        // Size check wraps modulo 2^64
                        if (body_size != img_w * img_h * 64'd3)
                            enter_error(ERR_SIZE, v.err);
                        else
                            phase = ST_CAPTION;
                    end
                end
                ST_CAPTION:
                begin
                    hdr_count = hdr_count + 1;
                    if (b == CHAR_NL) begin
                        v.role = ROLE_CAP_END;
                        phase  = ST_TAGS;
                    end else begin
                        v.role = ROLE_CAP_CHAR;
                        if (hdr_count >= hdr_size)
                            enter_error(ERR_LONG_HEADER, v.err);
                    end
                end
                ST_TAGS:
                begin
                    hdr_count     = hdr_count + 1;
                    tag_zero_last = (b == CHAR_NUL);
                    v.role        = tag_zero_last ? ROLE_TAG_END : ROLE_TAG_CHAR;
                    if (hdr_count >= hdr_size) begin
                        if (!tag_zero_last) begin
                            enter_error(ERR_TAG_UNTERM, v.err);
                        end else if (body_size == 64'd0) begin
                            v.done = 1'b1;
                            phase  = ST_DONE;
                        end else begin
                            phase = ST_PIXELS;
                        end
                    end
                end
                ST_PIXELS:
                begin
                    case (pix_count % 64'd3)
                        64'd0:   v.role = ROLE_RED;
                        64'd1:   v.role = ROLE_GREEN;
                        default: v.role = ROLE_BLUE;
                    endcase
                    pix_count = pix_count + 1;
                    if (pix_count == body_size) begin
                        v.done = 1'b1;
                        phase  = ST_DONE;
                    end
                end
                ST_ERROR:
                    v.err = sticky_err;
                default:
                    v.err = ERR_NONE;
            endcase
        end
    endtask

    task automatic report_mismatch(input string msg);
        fail_count = fail_count + 1;
        if (fail_count <= PRINT_LIMIT)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // Verdict check first: a verdict can never belong to a byte of this edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clear_parse_state();
            verdict_q.delete();
            fail_count    = 0;
            pending_count = 0;
        end else begin
            if (verdict.valid && verdict.ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("verdict with nothing pending: role %0d value %02h",
                                              verdict.byte_role, verdict.byte_value));
                end else begin
                    oldest = verdict_q.pop_front();
                    if (verdict.byte_role !== oldest.role
                        || verdict.byte_value !== oldest.value
                        || verdict.error_code !== oldest.err
                        || verdict.image_done !== oldest.done)
                        report_mismatch($sformatf(
                            "role %0d/%0d value %02h/%02h error %0d/%0d done %0b/%0b (got/exp)",
                            verdict.byte_role, oldest.role, verdict.byte_value, oldest.value,
                            verdict.error_code, oldest.err, verdict.image_done, oldest.done));
                end
            end
            if (stream.valid && stream.ready) begin
                classify_byte(stream.data_byte, stream.end_of_file, predicted);
                verdict_q.insert(verdict_q.size(), predicted);
            end
            pending_count = verdict_q.size();
        end
    end

endmodule

// ===== tb/image_container_stream_parser_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_container_stream_parser_top_test
// Feeds the container parser with directed byte sequences and random CIFF
// files (valid, corrupted, truncated, with trailing bytes) under several
// idle and stall patterns; the parse monitor does the checking.
// ----------------------------------------------------------------------------
module image_container_stream_parser_top_test;
    import icsp_pkg::*;

    localparam int QUIET_LIMIT     = 4000;
    localparam int TAIL_CYCLES     = 20;
    localparam int ITEMS_PER_PHASE = 380;
    localparam int MAX_PIXEL_BYTES = 60;

    logic clk;
    logic rst_n;

    icsp_byte_if   file_if ();
    icsp_result_if verdict_if ();

    int fail_count;
    int pending_count;
    int idle_pct;
    int stall_pct;
    int bytes_sent;
    int quiet_cycles;

    logic [7:0] file_q[$];

    image_container_stream_parser_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (file_if),
        .verdict (verdict_if)
    );

    icsp_parse_monitor u_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .stream        (file_if),
        .verdict       (verdict_if),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        verdict_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // One byte or end-of-file transfer, with random sender gaps
    task automatic send_byte(input logic [7:0] b, input logic eof);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            file_if.valid <= 1'b0;
            @(negedge clk);
        end
        file_if.valid       <= 1'b1;
        file_if.data_byte   <= b;
        file_if.end_of_file <= eof;
        @(posedge clk);
        while (!file_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Append one byte to the file under construction
    function automatic void add_byte(input logic [7:0] b);
        file_q.insert(file_q.size(), b);
    endfunction

    function automatic void push_le64(input logic [63:0] v);
        for (int k = 0; k < 8; k++)
            add_byte(v[8*k +: 8]);
    endfunction

    // Build one file, possibly broken, and send it followed by end-of-file
    task automatic send_random_file();
        int unsigned kind;
        int unsigned cap_len;
        int unsigned tag_len;
        int unsigned cut;
        logic [63:0] width;
        logic [63:0] height;
        logic [63:0] content;
        logic [63:0] hdr;
        logic [63:0] pixel_bytes;
        logic [7:0]  c;
        kind = $urandom_range(99);
        if ($urandom_range(9) == 0) begin
            // Wide dimensions: product wraps, pixels get cut short
            width  = {$urandom, $urandom};
            height = {$urandom, $urandom};
        end else begin
            width  = $urandom_range(0, 4);
            height = $urandom_range(0, 4);
        end
        content = width * height * 64'd3;
        cap_len = $urandom_range(0, 4);
        tag_len = $urandom_range(1, 5);
        hdr     = 64'd36 + cap_len + 1 + tag_len;

        if (kind >= 55 && kind < 62) begin
            content = content ^ (64'd1 << $urandom_range(63));
        end else if (kind >= 62 && kind < 69) begin
            // Header size ends inside the caption
            cap_len = $urandom_range(1, 4);
            hdr     = $urandom_range(0, 36 + cap_len);
        end else if (kind >= 75 && kind < 81) begin
            // Header size at most the fixed part plus newline and one tag byte: one tag byte ends it
            cap_len = 0;
            tag_len = 1;
            hdr     = $urandom_range(0, 38);
        end

        file_q.delete();
        add_byte(CHAR_C);
        add_byte(CHAR_I);
        add_byte(CHAR_F);
        add_byte(CHAR_F);
        push_le64(hdr);
        push_le64(content);
        push_le64(width);
        push_le64(height);
        for (int i = 0; i < cap_len; i++) begin
            do c = 8'($urandom); while (c == CHAR_NL);
            add_byte(c);
        end
        add_byte(CHAR_NL);
        for (int i = 0; i < tag_len; i++) begin
            if (i == tag_len - 1)
                c = (kind >= 69 && kind < 75) ? 8'($urandom_range(1, 255)) : CHAR_NUL;
            else
                c = ($urandom_range(3) == 0) ? CHAR_NUL : 8'($urandom);
            add_byte(c);
        end
        pixel_bytes = (content > MAX_PIXEL_BYTES) ? 64'(MAX_PIXEL_BYTES) : content;
        for (int i = 0; i < pixel_bytes; i++)
            add_byte(8'($urandom));

        if (kind >= 81 && kind < 87)
            file_q[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
        if (kind >= 87) begin
            cut = $urandom_range(0, file_q.size() - 1);
            while (file_q.size() > cut)
                file_q.delete(file_q.size() - 1);
        end
        // Bytes past the end of the image or after an error
        if ($urandom_range(2) == 0)
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom));

        foreach (file_q[i])
            send_byte(file_q[i], 1'b0);
        send_byte(8'($urandom), 1'b1);
    endtask

    // Watchdog: too long without any transfer
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (file_if.valid && file_if.ready)
                || (verdict_if.valid && verdict_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int target;
        rst_n               = 1'b0;
        file_if.valid       = 1'b0;
        file_if.data_byte   = 8'h00;
        file_if.end_of_file = 1'b0;
        verdict_if.ready    = 1'b0;
        idle_pct            = 0;
        stall_pct           = 0;
        bytes_sent          = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // End-of-file right after reset
        send_byte(8'hFF, 1'b1);
        // Bad first magic byte, byte after error, end with sticky error
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // End-of-file inside the magic
        send_byte(CHAR_C, 1'b0);
        send_byte(CHAR_I, 1'b0);
        send_byte(8'h00, 1'b1);
        // End-of-file inside the header fields
        send_byte(CHAR_C, 1'b0);
        send_byte(CHAR_I, 1'b0);
        send_byte(CHAR_F, 1'b0);
        send_byte(CHAR_F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b1);
        // Bad last magic byte
        send_byte(CHAR_C, 1'b0);
        send_byte(CHAR_I, 1'b0);
        send_byte(CHAR_F, 1'b0);
        send_byte(CHAR_C, 1'b0);
        send_byte(CHAR_NL, 1'b0);
        send_byte(8'hAA, 1'b1);

        // Random files under each idle and stall pattern
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 82; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            target = bytes_sent + ITEMS_PER_PHASE;
            while (bytes_sent < target)
                send_random_file();
        end

        @(negedge clk);
        file_if.valid <= 1'b0;
        stall_pct = 0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
